>>> src/fds_pkg.sv
// ----------------------------------------------------------------------------
// fds_pkg
// Types, constants and the round function shared by the differential space
// block and its pivot unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fds_pkg;

    localparam int ROW_W       = 32;
    localparam int ROWS        = 32;
    localparam int VEC_W       = 14;
    localparam int MAX_RESULTS = 14;
    localparam int CNT_W       = 6;
    localparam int KEEP_W      = 4;

    localparam logic VARIANT_SIMECK = 1'b0;
    localparam logic VARIANT_SIMON  = 1'b1;

    typedef logic [ROWS-1:0][ROW_W-1:0] t_row_bank;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_ELIM = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] pivot;
    } t_pivot_status;

    function automatic logic [ROW_W-1:0] round_fn(input logic [ROW_W-1:0] x,
                                                  input logic variant);
        logic [ROW_W-1:0] r1;
        logic [ROW_W-1:0] r2;
        logic [ROW_W-1:0] r5;
        logic [ROW_W-1:0] r8;
        logic [ROW_W-1:0] res;
        r1 = {x[30:0], x[31]};
        r2 = {x[29:0], x[31:30]};
        r5 = {x[26:0], x[31:27]};
        r8 = {x[23:0], x[31:24]};
        if (variant == VARIANT_SIMON) begin
            res = (r8 & r1) ^ r2;
        end else begin
            res = (r5 & x) ^ r1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/fds_pivot_unit.sv
// ----------------------------------------------------------------------------
// fds_pivot_unit
// One elimination step over the row bank: picks or forms the pivot row for
// the current column, clears that column in the remaining rows and rotates
// the finished pivot to the tail of the bank.
// ----------------------------------------------------------------------------
`default_nettype none

module fds_pivot_unit
    import fds_pkg::*;
(
    input  t_row_bank        i_rows,
    input  logic [ROW_W-1:0] i_col_mask,
    input  logic [CNT_W-1:0] i_done_rows,
    output t_row_bank        o_rows,
    output t_pivot_status    o_status
);

    localparam logic [CNT_W-1:0] ROWS_C = CNT_W'(ROWS);

    logic [ROWS-1:0]  col;
    logic [ROWS-1:0]  active;
    logic [ROWS-1:0]  others;
    logic [ROWS-1:0]  first;
    logic [ROW_W-1:0] sel;
    logic [ROW_W-1:0] pivot;
    logic             found;
    t_row_bank        red;

    always_comb begin
        sel = '0;
        for (int k = 0; k < ROWS; k++) begin
            col[k]    = |(i_rows[k] & i_col_mask);
            active[k] = (CNT_W'(k) + i_done_rows) < ROWS_C;
        end
        others    = col & active;
        others[0] = 1'b0;
        first     = others & (~others + ROWS'(1));
        for (int k = 0; k < ROWS; k++) begin
            if (first[k]) begin
                sel = sel | i_rows[k];
            end
        end
        pivot = col[0] ? i_rows[0] : (i_rows[0] ^ sel);
        found = col[0] | (|others);
        for (int k = 0; k < ROWS; k++) begin
            red[k] = others[k] ? (i_rows[k] ^ pivot) : i_rows[k];
        end
        if (found) begin
            for (int k = 0; k < ROWS - 1; k++) begin
                o_rows[k] = red[k+1];
            end
            o_rows[ROWS-1] = pivot;
        end else begin
            o_rows = i_rows;
        end
        o_status.found = found;
        o_status.pivot = pivot;
    end

endmodule

`default_nettype wire

>>> src/feistel_differential_space.sv
// ----------------------------------------------------------------------------
// feistel_differential_space
// Affine space of output differences of the Simeck or Simon round function
// for one input difference: derivative rows, GF(2) echelon reduction, offset
// reduction, then a transfer per kept basis vector, or one if none is kept.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | i_in_valid, o_in_ready, i_input_difference | in
//  result  | o_out_valid, i_out_ready, o_space_offset,  | out
//          | o_weight, o_offset_in_window,              |
//          | o_basis_vector, o_basis_valid, o_last      |
//  config  | i_cfg_wr_en, i_cfg_wr_data                 | in
//
// One item: acceptance, the build of the 32 rows, then one step per pivot
// or per dropped column in the shared pivot unit plus a closing step, then
// a scan of the finished rows until every kept result is sent (at most 14
// results).
// o_in_ready is high only while idle. Result stalls hold the scan.
// Reset is synchronous, active low, and returns to idle with the Simeck
// round function selected.
// ----------------------------------------------------------------------------
`default_nettype none

module feistel_differential_space
    import fds_pkg::*;
#(
    parameter int WINDOW = 14
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic               i_cfg_wr_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [ROW_W-1:0]   i_input_difference,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [ROW_W-1:0]        o_space_offset,
    output logic [CNT_W-1:0]        o_weight,
    output logic                    o_offset_in_window,
    output logic [VEC_W-1:0]        o_basis_vector,
    output logic                    o_basis_valid,
    output logic                    o_last
);

    localparam logic [ROW_W:0]    LIM      = (ROW_W+1)'(1) << WINDOW;
    localparam logic [ROW_W-1:0]  LOW_MASK = ROW_W'(LIM - (ROW_W+1)'(1));
    localparam logic [CNT_W-1:0]  ROWS_C   = CNT_W'(ROWS);
    localparam logic [CNT_W-1:0]  MAX_C    = CNT_W'(MAX_RESULTS);

    t_state             r_state, n_state;
    logic               r_variant;
    logic [ROW_W-1:0]   r_diff, n_diff;
    t_row_bank          r_rows, n_rows;
    logic [ROW_W-1:0]   r_offset, n_offset;
    logic [ROW_W-1:0]   r_mask, n_mask;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_win, n_win;
    logic [KEEP_W-1:0]  r_keep, n_keep;
    logic [KEEP_W-1:0]  r_sent, n_sent;

    logic               r_out_valid, n_out_valid;
    logic [ROW_W-1:0]   r_out_offset, n_out_offset;
    logic [CNT_W-1:0]   r_out_weight, n_out_weight;
    logic               r_out_inwin, n_out_inwin;
    logic [VEC_W-1:0]   r_out_vec, n_out_vec;
    logic               r_out_bvalid, n_out_bvalid;
    logic               r_out_last, n_out_last;

    t_row_bank          unit_rows;
    t_pivot_status      unit_status;

    fds_pivot_unit u_pivot (
        .i_rows      (r_rows),
        .i_col_mask  (r_mask),
        .i_done_rows (r_cnt),
        .o_rows      (unit_rows),
        .o_status    (unit_status)
    );

    always_comb begin
        logic             out_free;
        logic [ROW_W-1:0] b;
        logic [ROW_W-1:0] tail;
        logic             tail_kept;
        logic             is_last;

        n_state      = r_state;
        n_diff       = r_diff;
        n_rows       = r_rows;
        n_offset     = r_offset;
        n_mask       = r_mask;
        n_cnt        = r_cnt;
        n_win        = r_win;
        n_keep       = r_keep;
        n_sent       = r_sent;
        n_out_valid  = r_out_valid;
        n_out_offset = r_out_offset;
        n_out_weight = r_out_weight;
        n_out_inwin  = r_out_inwin;
        n_out_vec    = r_out_vec;
        n_out_bvalid = r_out_bvalid;
        n_out_last   = r_out_last;

        out_free  = !r_out_valid || i_out_ready;
        b         = round_fn(r_diff, r_variant);
        tail      = r_rows[ROWS-1];
        tail_kept = (tail != '0) && ((tail & ~LOW_MASK) == '0);
        is_last   = (r_sent + KEEP_W'(1)) == r_keep;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_diff  = i_input_difference;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                for (int k = 0; k < ROWS; k++) begin
                    n_rows[k] = round_fn(ROW_W'(1) << k, r_variant)
                              ^ round_fn(r_diff ^ (ROW_W'(1) << k), r_variant) ^ b;
                end
                n_offset = b;
                n_mask   = {1'b1, {(ROW_W-1){1'b0}}};
                n_cnt    = '0;
                n_win    = '0;
                n_sent   = '0;
                n_state  = ST_ELIM;
            end
            ST_ELIM: begin
                if (r_cnt == ROWS_C || r_mask == '0) begin
                    n_keep  = (r_win > MAX_C) ? KEEP_W'(MAX_RESULTS) : r_win[KEEP_W-1:0];
                    n_state = ST_EMIT;
                end else if (unit_status.found) begin
                    n_rows = unit_rows;
                    n_cnt  = r_cnt + CNT_W'(1);
                    if ((unit_status.pivot & ~LOW_MASK) == '0) begin
                        n_win = r_win + CNT_W'(1);
                    end
                    if ((r_offset & r_mask) != '0) begin
                        n_offset = r_offset ^ unit_status.pivot;
                    end
                end else begin
                    n_mask = r_mask >> 1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    if (r_keep == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_offset = r_offset;
                        n_out_weight = r_cnt;
                        n_out_inwin  = (r_offset & ~LOW_MASK) == '0;
                        n_out_vec    = '0;
                        n_out_bvalid = 1'b0;
                        n_out_last   = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        for (int k = ROWS - 1; k > 0; k--) begin
                            n_rows[k] = r_rows[k-1];
                        end
                        n_rows[0] = '0;
                        if (tail_kept) begin
                            n_out_valid  = 1'b1;
                            n_out_offset = r_offset;
                            n_out_weight = r_cnt;
                            n_out_inwin  = (r_offset & ~LOW_MASK) == '0;
                            n_out_vec    = tail[VEC_W-1:0];
                            n_out_bvalid = 1'b1;
                            n_out_last   = is_last;
                            n_sent       = r_sent + KEEP_W'(1);
                            if (is_last) begin
                                n_state = ST_IDLE;
                            end
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_variant   <= VARIANT_SIMECK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_variant <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff       <= n_diff;
        r_rows       <= n_rows;
        r_offset     <= n_offset;
        r_mask       <= n_mask;
        r_cnt        <= n_cnt;
        r_win        <= n_win;
        r_keep       <= n_keep;
        r_sent       <= n_sent;
        r_out_offset <= n_out_offset;
        r_out_weight <= n_out_weight;
        r_out_inwin  <= n_out_inwin;
        r_out_vec    <= n_out_vec;
        r_out_bvalid <= n_out_bvalid;
        r_out_last   <= n_out_last;
    end

    assign o_in_ready         = (r_state == ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_space_offset     = r_out_offset;
    assign o_weight           = r_out_weight;
    assign o_offset_in_window = r_out_inwin;
    assign o_basis_vector     = r_out_vec;
    assign o_basis_valid      = r_out_bvalid;
    assign o_last             = r_out_last;

endmodule

`default_nettype wire

>>> verif/feistel_differential_space_tb.sv
// ----------------------------------------------------------------------------
// feistel_differential_space_tb
// Drives input differences into the differential space block under both
// round functions and checks every result transfer against a predictor that
// builds the derivative rows, reduces them over GF(2) and lists the basis
// vectors that fall inside the window. Both sides idle and stall at random;
// one long result hold-off fills the block and stalls its input.
// ----------------------------------------------------------------------------
module feistel_differential_space_tb;
    import fds_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 120;
    localparam int HOLD_CYCLES    = 400;
    localparam logic [ROW_W-1:0] WINDOW_LIMIT = 32'h0000_4000;

    localparam logic [ROW_W-1:0] CORNER_DIFFS [12] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
        32'h0000_3FFF, 32'hFFFF_C000, 32'hAAAA_AAAA, 32'h5555_5555,
        32'h7FFF_FFFF, 32'h0000_0021, 32'h0001_2345, 32'hDEAD_BEEF
    };

    typedef struct packed {
        logic [ROW_W-1:0] offset;
        logic [CNT_W-1:0] weight;
        logic             in_window;
        logic [VEC_W-1:0] vec;
        logic             vec_valid;
        logic             last;
    } t_space_xfer;

    class affine_space_board;
        logic        variant;
        t_space_xfer owed_results[$];
        int          fails;

        function new();
            variant = VARIANT_SIMECK;
            fails   = 0;
        endfunction

        function logic [ROW_W-1:0] rotl(input logic [ROW_W-1:0] x, input int n);
            return (x << n) | (x >> (ROW_W - n));
        endfunction

        function logic [ROW_W-1:0] feistel_f(input logic [ROW_W-1:0] x);
            if (variant == VARIANT_SIMON) begin
                return (rotl(x, 8) & rotl(x, 1)) ^ rotl(x, 2);
            end
            return (rotl(x, 5) & x) ^ rotl(x, 1);
        endfunction

        function void note_difference(input logic [ROW_W-1:0] d);
            logic [ROW_W-1:0] rows [ROWS];
            logic [ROW_W-1:0] kept [MAX_RESULTS];
            logic [ROW_W-1:0] offs;
            logic [ROW_W-1:0] unit;
            logic [CNT_W-1:0] rank;
            logic             found;
            t_space_xfer      x;
            int               p;
            int               nk;
            int               n;
            offs = feistel_f('0) ^ feistel_f(d);
            for (int i = 0; i < ROWS; i++) begin
                unit    = 32'h1 << i;
                rows[i] = feistel_f(unit) ^ feistel_f(d ^ unit) ^ offs;
            end
            p = ROW_W - 1;
            for (int i = 0; i < ROWS; i++) begin
                found = 1'b0;
                while (p >= 0 && rows[i][p] == 1'b0) begin
                    for (int j = i + 1; j < ROWS; j++) begin
                        if (rows[j][p]) begin
                            rows[i] ^= rows[j];
                            found = 1'b1;
                            break;
                        end
                    end
                    if (found) break;
                    p--;
                end
                if (p < 0) break;
                for (int j = i + 1; j < ROWS; j++) begin
                    if (rows[j][p]) rows[j] ^= rows[i];
                end
                if (offs[p]) offs ^= rows[i];
            end
            rank = '0;
            nk   = 0;
            for (int i = ROWS - 1; i >= 0; i--) begin
                if (rows[i] != '0) begin
                    rank++;
                    if (rows[i] < WINDOW_LIMIT && nk < MAX_RESULTS) begin
                        kept[nk] = rows[i];
                        nk++;
                    end
                end
            end
            n = (nk > 0) ? nk : 1;
            for (int i = 0; i < n; i++) begin
                x.offset    = offs;
                x.weight    = rank;
                x.in_window = (offs < WINDOW_LIMIT);
                x.vec       = (nk > 0) ? kept[i][VEC_W-1:0] : '0;
                x.vec_valid = (nk > 0);
                x.last      = (i == n - 1);
                owed_results.push_back(x);
            end
        endfunction

        function bit field_bad(input string name, input logic [ROW_W-1:0] want,
                               input logic [ROW_W-1:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void check_transfer(input t_space_xfer got);
            t_space_xfer want;
            bit          bad;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, got);
                fails++;
                return;
            end
            want = owed_results.pop_front();
            bad  = field_bad("space_offset", want.offset, got.offset);
            bad |= field_bad("weight", ROW_W'(want.weight), ROW_W'(got.weight));
            bad |= field_bad("offset_in_window", ROW_W'(want.in_window),
                             ROW_W'(got.in_window));
            bad |= field_bad("basis_vector", ROW_W'(want.vec), ROW_W'(got.vec));
            bad |= field_bad("basis_valid", ROW_W'(want.vec_valid), ROW_W'(got.vec_valid));
            bad |= field_bad("last", ROW_W'(want.last), ROW_W'(got.last));
            if (bad) fails++;
        endfunction
    endclass

    logic             i_clk              = 1'b0;
    logic             i_rst_n            = 1'b0;
    logic             i_cfg_wr_en        = 1'b0;
    logic             i_cfg_wr_data      = 1'b0;
    logic             i_in_valid         = 1'b0;
    logic [ROW_W-1:0] i_input_difference = '0;
    logic             i_out_ready        = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [ROW_W-1:0] o_space_offset;
    logic [CNT_W-1:0] o_weight;
    logic             o_offset_in_window;
    logic [VEC_W-1:0] o_basis_vector;
    logic             o_basis_valid;
    logic             o_last;

    affine_space_board board;
    int                tx_idle_pct  = 0;
    int                rx_idle_pct  = 0;
    logic              rx_hold_req  = 1'b0;
    int                rx_hold_left = 0;
    int                quiet_cycles = 0;

    feistel_differential_space dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_wr_data      (i_cfg_wr_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_input_difference (i_input_difference),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_space_offset     (o_space_offset),
        .o_weight           (o_weight),
        .o_offset_in_window (o_offset_in_window),
        .o_basis_vector     (o_basis_vector),
        .o_basis_valid      (o_basis_valid),
        .o_last             (o_last)
    );

    always #5 i_clk = ~i_clk;

    // hold the result side off on request, else stall at random
    always @(posedge i_clk) begin
        if (rx_hold_left != 0) begin
            i_out_ready  <= 1'b0;
            rx_hold_left <= rx_hold_left - 1;
        end else if (rx_hold_req) begin
            i_out_ready  <= 1'b0;
            rx_hold_left <= HOLD_CYCLES;
            rx_hold_req  <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            board.check_transfer(t_space_xfer'{o_space_offset, o_weight, o_offset_in_window,
                                               o_basis_vector, o_basis_valid, o_last});
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [ROW_W-1:0] pick_difference();
        logic [ROW_W-1:0] v;
        case ($urandom_range(3))
            0, 1: v = $urandom;
            2: begin
                v = 32'h1 << $urandom_range(31);
                if ($urandom_range(1)) v |= 32'h1 << $urandom_range(31);
            end
            default: v = $urandom >> $urandom_range(31);
        endcase
        return v;
    endfunction

    task automatic send_difference(input logic [ROW_W-1:0] d);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        i_in_valid         <= 1'b1;
        i_input_difference <= d;
        do @(posedge i_clk); while (!o_in_ready);
        board.note_difference(d);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.owed_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_variant(input logic v);
        drain_results();
        while (!o_in_ready) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        board.variant = v;
    endtask

    task automatic send_random(input int count);
        repeat (count) send_difference(pick_difference());
    endtask

    initial begin
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_variant(VARIANT_SIMECK);
        foreach (CORNER_DIFFS[k]) send_difference(CORNER_DIFFS[k]);
        write_variant(VARIANT_SIMON);
        foreach (CORNER_DIFFS[k]) send_difference(CORNER_DIFFS[k]);

        tx_idle_pct = 16;
        rx_idle_pct = 78;
        send_random(130);

        write_variant(VARIANT_SIMECK);
        tx_idle_pct = 78;
        rx_idle_pct = 16;
        send_random(130);

        write_variant(VARIANT_SIMON);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_req <= 1'b1;
        send_random(70);

        // pause until every owed result has arrived
        drain_results();
        write_variant(VARIANT_SIMECK);
        send_random(70);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.fails == 0 && board.owed_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
